FILE: sv/axis_vector_rotation_macros.svh
// Assertion helpers shared by the axis_vector_rotation RTL.
// The including scope provides clk and rst.
`ifndef AXIS_VECTOR_ROTATION_MACROS_SVH
`define AXIS_VECTOR_ROTATION_MACROS_SVH

`ifndef SYNTHESIS

`define AVR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("axis_vector_rotation: same-cycle check failed");

`define AVR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("axis_vector_rotation: next-cycle check failed");

`else

`define AVR_ASSERT_IMP(lbl, ante, cons)

`define AVR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: sv/avr_pkg.sv
package avr_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int ROT_STEPS   = 16;

  localparam int TURN_W    = 16;
  localparam int ANG_SHIFT = 16;
  localparam int GUARD     = 8;
  localparam int K_FRAC    = 30;

  localparam int DW     = (COORD_WIDTH + GUARD + 3 > K_FRAC + 2) ?
                          COORD_WIDTH + GUARD + 3 : K_FRAC + 2;
  localparam int AW     = TURN_W + ANG_SHIFT + 1;
  localparam int STEP_W = (ROT_STEPS > 1) ? $clog2(ROT_STEPS) : 1;
  localparam int MAG_W  = DW - 1;
  localparam int MH_W   = MAG_W - K_FRAC;
  localparam int R_W    = MAG_W + 1 - GUARD;
  localparam int SV_W   = R_W + 1;

  localparam int SCALE_LAT = 4;

  localparam logic signed [AW-1:0] ANG_PI      = AW'(843314857);
  localparam logic signed [AW-1:0] ANG_HALF_PI = AW'(421657428);
  localparam logic signed [AW-1:0] ANG_TWO_PI  = AW'(1686629713);

  localparam logic [K_FRAC-1:0] GAIN_Q = K_FRAC'(652032874);

  localparam logic [1:0] KIND_X    = 2'd0;
  localparam logic [1:0] KIND_Y    = 2'd1;
  localparam logic [1:0] KIND_Z    = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic signed [AW-1:0] ARC_TAB [10] = '{
    AW'(210828714), AW'(124459457), AW'(65760959), AW'(33381290), AW'(16755422),
    AW'(8385879),   AW'(4193963),   AW'(2097109),  AW'(1048571),  AW'(524287)
  };

  typedef struct packed {
    logic signed [DW-1:0] u;
    logic signed [DW-1:0] v;
    logic signed [AW-1:0] a;
  } rot_t;

  typedef struct packed {
    logic [1:0]                    kind;
    logic                          bypass;
    logic signed [COORD_WIDTH-1:0] pass;
  } side_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] rx;
    logic signed [COORD_WIDTH-1:0] ry;
    logic signed [COORD_WIDTH-1:0] rz;
    logic                          clipped;
  } res_t;

  function automatic logic signed [AW-1:0] arc_at(input int i);
    logic signed [AW-1:0] r;
    r = '0;
    if (i < 10) begin
      r = ARC_TAB[i[3:0]];
    end else if (i <= 28) begin
      r = AW'(64'sd1 << (28 - i));
    end
    return r;
  endfunction

endpackage

FILE: sv/avr_if.sv
interface avr_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             kind;
  logic signed [avr_pkg::COORD_WIDTH-1:0] px;
  logic signed [avr_pkg::COORD_WIDTH-1:0] py;
  logic signed [avr_pkg::COORD_WIDTH-1:0] pz;
  logic signed [avr_pkg::TURN_W-1:0]      turn;

  modport source (output valid, kind, px, py, pz, turn, input ready);
  modport sink   (input valid, kind, px, py, pz, turn, output ready);
endinterface

interface avr_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [avr_pkg::COORD_WIDTH-1:0] rx;
  logic signed [avr_pkg::COORD_WIDTH-1:0] ry;
  logic signed [avr_pkg::COORD_WIDTH-1:0] rz;
  logic                                   clipped;

  modport source (output valid, rx, ry, rz, clipped, input ready);
  modport sink   (input valid, rx, ry, rz, clipped, output ready);
endinterface

FILE: sv/avr_prep.sv
`include "axis_vector_rotation_macros.svh"

module avr_prep (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   run,
  input  logic                                   in_valid,
  input  logic [1:0]                             kind,
  input  logic signed [avr_pkg::COORD_WIDTH-1:0] px,
  input  logic signed [avr_pkg::COORD_WIDTH-1:0] py,
  input  logic signed [avr_pkg::COORD_WIDTH-1:0] pz,
  input  logic signed [avr_pkg::TURN_W-1:0]      turn,
  output logic                                   out_valid,
  output avr_pkg::rot_t                          beat,
  output avr_pkg::side_t                         side
);

  localparam int CW = avr_pkg::COORD_WIDTH;
  localparam int DW = avr_pkg::DW;
  localparam int AW = avr_pkg::AW;
  localparam int GUARD = avr_pkg::GUARD;

  logic signed [AW-1:0] a0;
  logic signed [AW-1:0] a1;
  logic signed [CW-1:0] u1;
  logic signed [CW-1:0] v1;
  logic signed [CW-1:0] pass1;

  logic                 s1_valid;
  logic signed [CW-1:0] s1_u;
  logic signed [CW-1:0] s1_v;
  logic signed [AW-1:0] s1_a;
  avr_pkg::side_t       s1_side;

  logic                 hi;
  logic                 lo;
  logic                 neg;
  logic signed [AW-1:0] a2;
  logic signed [DW-1:0] ue;
  logic signed [DW-1:0] ve;
  avr_pkg::rot_t        beat_next;

  assign a0 = {{(AW - avr_pkg::TURN_W - avr_pkg::ANG_SHIFT){turn[avr_pkg::TURN_W-1]}},
               turn, {avr_pkg::ANG_SHIFT{1'b0}}};

  always_comb begin
    priority if (a0 > avr_pkg::ANG_PI) begin
      a1 = a0 - avr_pkg::ANG_TWO_PI;
    end else if (a0 < -avr_pkg::ANG_PI) begin
      a1 = a0 + avr_pkg::ANG_TWO_PI;
    end else begin
      a1 = a0;
    end
  end

  always_comb begin
    unique case (kind)
      avr_pkg::KIND_X: begin
        u1 = pz; v1 = py; pass1 = px;
      end
      avr_pkg::KIND_Y: begin
        u1 = px; v1 = pz; pass1 = py;
      end
      default: begin
        u1 = px; v1 = py; pass1 = pz;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (run) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      s1_u <= u1;
      s1_v <= v1;
      s1_a <= a1;
      s1_side.kind <= kind;
      s1_side.bypass <= (kind == avr_pkg::KIND_NONE);
      s1_side.pass <= pass1;
    end
  end

  // fold into [-pi/2, pi/2] by turning the pair by pi
  assign hi = s1_a > avr_pkg::ANG_HALF_PI;
  assign lo = s1_a < -avr_pkg::ANG_HALF_PI;
  assign neg = (hi || lo) && !s1_side.bypass;
  assign ue = {{(DW - CW - GUARD){s1_u[CW-1]}}, s1_u, {GUARD{1'b0}}};
  assign ve = {{(DW - CW - GUARD){s1_v[CW-1]}}, s1_v, {GUARD{1'b0}}};

  always_comb begin
    priority if (hi) begin
      a2 = s1_a - avr_pkg::ANG_PI;
    end else if (lo) begin
      a2 = s1_a + avr_pkg::ANG_PI;
    end else begin
      a2 = s1_a;
    end
    beat_next.u = neg ? -ue : ue;
    beat_next.v = neg ? -ve : ve;
    beat_next.a = a2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (run) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      beat <= beat_next;
      side <= s1_side;
    end
  end

  `AVR_ASSERT_IMP(a_angle_folded, out_valid && !side.bypass, (beat.a <= avr_pkg::ANG_HALF_PI) && (beat.a >= -avr_pkg::ANG_HALF_PI))

endmodule

FILE: sv/avr_cell.sv
module avr_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              run,
  input  logic                              in_valid,
  input  avr_pkg::rot_t                     in_beat,
  input  avr_pkg::side_t                    in_side,
  input  logic [avr_pkg::STEP_W-1:0]        step,
  input  logic signed [avr_pkg::AW-1:0]     arc,
  output logic                              out_valid,
  output avr_pkg::rot_t                     out_beat,
  output avr_pkg::side_t                    out_side
);

  logic signed [avr_pkg::DW-1:0] bu;
  logic signed [avr_pkg::DW-1:0] bv;
  logic signed [avr_pkg::DW-1:0] du;
  logic signed [avr_pkg::DW-1:0] dv;
  avr_pkg::rot_t                 beat_next;

  assign bu = in_beat.u;
  assign bv = in_beat.v;
  assign du = bv >>> step;
  assign dv = bu >>> step;

  always_comb begin
    priority if (in_side.bypass) begin
      beat_next = in_beat;
    end else if (!in_beat.a[avr_pkg::AW-1]) begin
      beat_next.u = bu - du;
      beat_next.v = bv + dv;
      beat_next.a = in_beat.a - arc;
    end else begin
      beat_next.u = bu + du;
      beat_next.v = bv - dv;
      beat_next.a = in_beat.a + arc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (run) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      out_beat <= beat_next;
      out_side <= in_side;
    end
  end

endmodule

FILE: sv/avr_scale.sv
module avr_scale (
  input  logic                                   clk,
  input  logic                                   run,
  input  logic signed [avr_pkg::DW-1:0]          in_val,
  input  logic                                   bypass,
  output logic signed [avr_pkg::COORD_WIDTH-1:0] res,
  output logic                                   clip
);

  localparam int CW     = avr_pkg::COORD_WIDTH;
  localparam int MAG_W  = avr_pkg::MAG_W;
  localparam int K_FRAC = avr_pkg::K_FRAC;
  localparam int R_W    = avr_pkg::R_W;
  localparam int SV_W   = avr_pkg::SV_W;
  localparam int GUARD  = avr_pkg::GUARD;

  localparam logic [MAG_W:0] RND = (MAG_W+1)'(1) << (GUARD - 1);
  localparam logic signed [SV_W-1:0] SAT_HI = {{(SV_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SV_W-1:0] SAT_LO = ~SAT_HI;

  logic [MAG_W-1:0]       s1_m;
  logic                   s1_neg;
  logic                   s1_byp;
  logic signed [CW-1:0]   s1_bv;

  logic [MAG_W-1:0]       s2_ph;
  logic [2*K_FRAC-1:0]    s2_pl;
  logic                   s2_neg;
  logic                   s2_byp;
  logic signed [CW-1:0]   s2_bv;

  logic [MAG_W-1:0]       w;
  logic [MAG_W:0]         rsum;
  logic [R_W-1:0]         s3_r;
  logic                   s3_neg;
  logic                   s3_byp;
  logic signed [CW-1:0]   s3_bv;

  logic signed [SV_W-1:0] sv;

  always_ff @(posedge clk) begin
    if (run) begin
      s1_m   <= in_val[avr_pkg::DW-1] ? MAG_W'(-in_val) : MAG_W'(in_val);
      s1_neg <= in_val[avr_pkg::DW-1];
      s1_byp <= bypass;
      s1_bv  <= in_val[CW+GUARD-1:GUARD];
    end
  end

  // gain split into two partial products
  always_ff @(posedge clk) begin
    if (run) begin
      s2_ph  <= MAG_W'(s1_m[MAG_W-1:K_FRAC]) * MAG_W'(avr_pkg::GAIN_Q);
      s2_pl  <= (2*K_FRAC)'(s1_m[K_FRAC-1:0]) * (2*K_FRAC)'(avr_pkg::GAIN_Q);
      s2_neg <= s1_neg;
      s2_byp <= s1_byp;
      s2_bv  <= s1_bv;
    end
  end

  assign w    = s2_ph + MAG_W'(s2_pl[2*K_FRAC-1:K_FRAC]);
  assign rsum = {1'b0, w} + RND;

  always_ff @(posedge clk) begin
    if (run) begin
      s3_r   <= rsum[MAG_W:GUARD];
      s3_neg <= s2_neg;
      s3_byp <= s2_byp;
      s3_bv  <= s2_bv;
    end
  end

  assign sv = s3_neg ? -$signed({1'b0, s3_r}) : $signed({1'b0, s3_r});

  always_ff @(posedge clk) begin
    if (run) begin
      priority if (s3_byp) begin
        res  <= s3_bv;
        clip <= 1'b0;
      end else if (sv > SAT_HI) begin
        res  <= SAT_HI[CW-1:0];
        clip <= 1'b1;
      end else if (sv < SAT_LO) begin
        res  <= SAT_LO[CW-1:0];
        clip <= 1'b1;
      end else begin
        res  <= sv[CW-1:0];
        clip <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/axis_vector_rotation.sv
// axis_vector_rotation: rotates a 3D point (Q16.16) about the x, y or z axis
// by an angle in radians (Q4.12), CORDIC in a chain of micro-rotation cells.
// point  : valid/ready sink, one beat = kind, px, py, pz, turn.
// result : valid/ready source, one beat = rx, ry, rz, clipped.
// One result beat per point beat, in order. A kind of 3 passes the point
// through unchanged. Out-of-range results saturate and set clipped.
// Pipeline: two fold stages, one cell per CORDIC step, four gain/saturate
// stages and the output register; each cell owns one step of the iteration.
// Throughput: one point per cycle while the receiver is not stalling.
// A stalled receiver: the output register holds its beat and one more beat
// lands in a skid register; point.ready then drops and the whole chain
// freezes until the output register drains. point.ready comes from a flop.
// Reset (rst, synchronous) clears all valid bits; the chain is empty and
// ready to accept on the first cycle after reset.
`include "axis_vector_rotation_macros.svh"

module axis_vector_rotation (
  input  logic           clk,
  input  logic           rst,
  avr_in_if.sink         point,
  avr_out_if.source      result
);

  localparam int NS  = avr_pkg::ROT_STEPS;
  localparam int LAT = avr_pkg::SCALE_LAT;

  logic                    run;
  logic                    c_valid [NS+1];
  avr_pkg::rot_t           c_beat  [NS+1];
  avr_pkg::side_t          c_side  [NS+1];

  logic                    vld_s   [LAT];
  avr_pkg::side_t          side_s  [LAT];

  logic signed [avr_pkg::COORD_WIDTH-1:0] cu;
  logic signed [avr_pkg::COORD_WIDTH-1:0] cv;
  logic                    clip_u;
  logic                    clip_v;

  logic                    l_valid;
  avr_pkg::side_t          l_side;
  avr_pkg::res_t           l_data;
  logic                    leaving;

  logic                    ov;
  avr_pkg::res_t           od;
  logic                    skid_v;
  avr_pkg::res_t           sd;

  assign run = !skid_v;
  assign point.ready = run;

  avr_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .run       (run),
    .in_valid  (point.valid),
    .kind      (point.kind),
    .px        (point.px),
    .py        (point.py),
    .pz        (point.pz),
    .turn      (point.turn),
    .out_valid (c_valid[0]),
    .beat      (c_beat[0]),
    .side      (c_side[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_cell
    avr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .run       (run),
      .in_valid  (c_valid[k]),
      .in_beat   (c_beat[k]),
      .in_side   (c_side[k]),
      .step      (avr_pkg::STEP_W'(k)),
      .arc       (avr_pkg::arc_at(k)),
      .out_valid (c_valid[k+1]),
      .out_beat  (c_beat[k+1]),
      .out_side  (c_side[k+1])
    );
  end

  avr_scale u_scale_u (
    .clk    (clk),
    .run    (run),
    .in_val (c_beat[NS].u),
    .bypass (c_side[NS].bypass),
    .res    (cu),
    .clip   (clip_u)
  );

  avr_scale u_scale_v (
    .clk    (clk),
    .run    (run),
    .in_val (c_beat[NS].v),
    .bypass (c_side[NS].bypass),
    .res    (cv),
    .clip   (clip_v)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        vld_s[i] <= 1'b0;
      end
    end else if (run) begin
      vld_s[0] <= c_valid[NS];
      for (int i = 1; i < LAT; i++) begin
        vld_s[i] <= vld_s[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      side_s[0] <= c_side[NS];
      for (int i = 1; i < LAT; i++) begin
        side_s[i] <= side_s[i-1];
      end
    end
  end

  assign l_valid = vld_s[LAT-1];
  assign l_side  = side_s[LAT-1];
  assign leaving = l_valid && run;

  always_comb begin
    l_data.clipped = clip_u || clip_v;
    unique case (l_side.kind)
      avr_pkg::KIND_X: begin
        l_data.rx = l_side.pass; l_data.ry = cv; l_data.rz = cu;
      end
      avr_pkg::KIND_Y: begin
        l_data.rx = cu; l_data.ry = l_side.pass; l_data.rz = cv;
      end
      default: begin
        l_data.rx = cu; l_data.ry = cv; l_data.rz = l_side.pass;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov     <= 1'b0;
      skid_v <= 1'b0;
    end else if (!ov || result.ready) begin
      if (skid_v) begin
        ov     <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        ov <= leaving;
      end
    end else if (leaving) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || result.ready) begin
      od <= skid_v ? sd : l_data;
    end
    if (ov && !result.ready && leaving) begin
      sd <= l_data;
    end
  end

  assign result.valid   = ov;
  assign result.rx      = od.rx;
  assign result.ry      = od.ry;
  assign result.rz      = od.rz;
  assign result.clipped = od.clipped;

  `AVR_ASSERT_IMP(a_skid_behind_out, skid_v, ov)
  `AVR_ASSERT_NEXT(a_stall_fills_skid, ov && !result.ready && leaving, skid_v && !point.ready)
  `AVR_ASSERT_IMP(a_bypass_no_clip, l_valid && l_side.bypass, !clip_u && !clip_v)

endmodule

FILE: tb/axis_vector_rotation_tb.sv
`timescale 1ns / 1ps

module axis_vector_rotation_tb;

  localparam int ROT_STEPS = avr_pkg::ROT_STEPS;
  localparam logic [1:0] KIND_X    = avr_pkg::KIND_X;
  localparam logic [1:0] KIND_Y    = avr_pkg::KIND_Y;
  localparam logic [1:0] KIND_Z    = avr_pkg::KIND_Z;
  localparam logic [1:0] KIND_NONE = avr_pkg::KIND_NONE;

  typedef avr_pkg::res_t res_t;

  localparam longint PI_Q28      = 843314857;
  localparam longint HALF_PI_Q28 = 421657428;
  localparam longint TWO_PI_Q28  = 1686629713;
  localparam logic [29:0] KGAIN_Q30 = 30'd652032874;
  localparam int CORDIC_GUARD = 8;
  localparam longint ATAN_Q28 [10] = '{
    210828714, 124459457, 65760959, 33381290, 16755422,
    8385879, 4193963, 2097109, 1048571, 524287
  };

  localparam logic signed [31:0] COORD_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] COORD_MIN = 32'sh80000000;
  localparam logic signed [31:0] ONE_Q16   = 32'sh00010000;
  localparam int PIPE_DEPTH     = ROT_STEPS + 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_VERTICES = 1530;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] turn;
  } vertex_t;

  typedef enum {FLOW_FREE, FLOW_RANDOM, FLOW_PATTERN, FLOW_CHOKE} flow_e;

  logic clk;
  logic rst;

  avr_in_if  point_bus ();
  avr_out_if result_bus ();

  axis_vector_rotation dut (
    .clk    (clk),
    .rst    (rst),
    .point  (point_bus),
    .result (result_bus)
  );

  vertex_t vertex_queue [$];
  res_t    rotated_queue [$];
  int      mismatches;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic longint atan_step(input int i);
    if (i < 10) return ATAN_Q28[i];
    if (i <= 28) return longint'(1) << (28 - i);
    return 0;
  endfunction

  function automatic longint apply_gain(input longint s);
    logic [95:0] mag;
    logic [95:0] w;
    longint r;
    mag = (s < 0) ? 96'(-s) : 96'(s);
    w = (mag * 96'(KGAIN_Q30)) >> 30;
    r = longint'((w + 96'd128) >> CORDIC_GUARD);
    return (s < 0) ? -r : r;
  endfunction

  function automatic void rotate_pair(inout longint u, inout longint v, input longint a);
    longint cu;
    longint cv;
    longint du;
    longint dv;
    int i;
    cu = u * 256;
    cv = v * 256;
    if (a > PI_Q28) a -= TWO_PI_Q28;
    if (a < -PI_Q28) a += TWO_PI_Q28;
    if (a > HALF_PI_Q28) begin
      a -= PI_Q28;
      cu = -cu;
      cv = -cv;
    end else if (a < -HALF_PI_Q28) begin
      a += PI_Q28;
      cu = -cu;
      cv = -cv;
    end
    for (i = 0; i < ROT_STEPS; i++) begin
      du = cv >>> i;
      dv = cu >>> i;
      if (a >= 0) begin
        cu -= du;
        cv += dv;
        a -= atan_step(i);
      end else begin
        cu += du;
        cv -= dv;
        a += atan_step(i);
      end
    end
    u = apply_gain(cu);
    v = apply_gain(cv);
  endfunction

  function automatic logic signed [31:0] clamp_coord(input longint v, inout bit clip);
    if (v > longint'(COORD_MAX)) begin
      clip = 1'b1;
      return COORD_MAX;
    end
    if (v < longint'(COORD_MIN)) begin
      clip = 1'b1;
      return COORD_MIN;
    end
    return 32'(v);
  endfunction

  function automatic res_t rotate_vertex(input vertex_t p);
    longint x;
    longint y;
    longint z;
    longint a;
    bit clip;
    res_t r;
    x = p.px;
    y = p.py;
    z = p.pz;
    a = longint'(p.turn) * 65536;
    case (p.kind)
      KIND_X: rotate_pair(z, y, a);
      KIND_Y: rotate_pair(x, z, a);
      KIND_Z: rotate_pair(x, y, a);
      default: ;
    endcase
    clip = 1'b0;
    r.rx = clamp_coord(x, clip);
    r.ry = clamp_coord(y, clip);
    r.rz = clamp_coord(z, clip);
    r.clipped = clip;
    return r;
  endfunction

  function automatic vertex_t make_vertex(input logic [1:0] kind, input logic signed [31:0] x,
                                          input logic signed [31:0] y,
                                          input logic signed [31:0] z,
                                          input logic signed [15:0] t);
    vertex_t p;
    p.kind = kind;
    p.px = x;
    p.py = y;
    p.pz = z;
    p.turn = t;
    return p;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      1: return $signed($urandom_range(0, 2097152)) - 1048576;
      2: return $signed($urandom_range(0, 2)) - 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_turn();
    logic signed [15:0] edges [10];
    edges = '{16'sd6433, 16'sd6434, 16'sd12867, 16'sd12868, -16'sd6433,
              -16'sd6434, -16'sd12867, -16'sd12868, 16'sd32767, -16'sd32768};
    if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 9)];
    return 16'($urandom);
  endfunction

  task automatic drain_all();
    while (vertex_queue.size() != 0 || point_bus.valid || rotated_queue.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // sender: bursts with gaps in between
  vertex_t presented;
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      point_bus.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (point_bus.valid && point_bus.ready)
        rotated_queue.push_back(rotate_vertex(presented));
      if (!(point_bus.valid && !point_bus.ready)) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0 || vertex_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          point_bus.valid <= 1'b0;
        end else begin
          presented = vertex_queue.pop_front();
          point_bus.kind  <= presented.kind;
          point_bus.px    <= presented.px;
          point_bus.py    <= presented.py;
          point_bus.pz    <= presented.pz;
          point_bus.turn  <= presented.turn;
          point_bus.valid <= 1'b1;
          burst_left--;
        end
      end
    end
  end

  // receiver backpressure
  flow_e      flow_mode;
  int         flow_left;
  logic [7:0] flow_pattern;
  logic       take;

  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      flow_left = 0;
    end else begin
      if (flow_left == 0) begin
        flow_mode = flow_e'($urandom_range(0, 3));
        flow_left = $urandom_range(16, 160);
        flow_pattern = 8'($urandom);
      end
      flow_left--;
      case (flow_mode)
        FLOW_FREE: take = 1'b1;
        FLOW_RANDOM: take = ($urandom_range(0, 3) != 0);
        FLOW_PATTERN: begin
          take = flow_pattern[0];
          flow_pattern = {flow_pattern[0], flow_pattern[7:1]};
        end
        default: take = ($urandom_range(0, 7) == 0);
      endcase
      result_bus.ready <= take;
    end
  end

  // result checker
  res_t want;

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (rotated_queue.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, actual %h %h %h %b", $time,
                 result_bus.rx, result_bus.ry, result_bus.rz, result_bus.clipped);
      end else begin
        want = rotated_queue.pop_front();
        check_field("rx", want.rx, result_bus.rx);
        check_field("ry", want.ry, result_bus.ry);
        check_field("rz", want.rz, result_bus.rz);
        check_field("clipped", 32'(want.clipped), 32'(result_bus.clipped));
      end
    end
  end

  // stall watchdog
  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (point_bus.valid && point_bus.ready) ||
        (result_bus.valid && result_bus.ready) ||
        (vertex_queue.size() == 0 && !point_bus.valid && rotated_queue.size() == 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("axis_vector_rotation regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int k;
    int n;
    mismatches = 0;
    rst = 1'b1;
    point_bus.valid = 1'b0;
    point_bus.kind = KIND_X;
    point_bus.px = '0;
    point_bus.py = '0;
    point_bus.pz = '0;
    point_bus.turn = '0;
    result_bus.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // fold boundaries, angle extremes, saturation, pass-through
    vertex_queue.push_back(make_vertex(KIND_Z, ONE_Q16, 0, 0, 0));
    vertex_queue.push_back(make_vertex(KIND_Z, ONE_Q16, 0, 0, 16'sd6434));
    vertex_queue.push_back(make_vertex(KIND_Z, ONE_Q16, ONE_Q16, 0, 16'sd6433));
    vertex_queue.push_back(make_vertex(KIND_Z, ONE_Q16, -ONE_Q16, 5, 16'sd12868));
    vertex_queue.push_back(make_vertex(KIND_Z, -ONE_Q16, ONE_Q16, 0, 16'sd12867));
    vertex_queue.push_back(make_vertex(KIND_Y, ONE_Q16, 7, -ONE_Q16, -16'sd6434));
    vertex_queue.push_back(make_vertex(KIND_Y, -ONE_Q16, 3, ONE_Q16, -16'sd6433));
    vertex_queue.push_back(make_vertex(KIND_Y, ONE_Q16, 0, ONE_Q16, -16'sd12868));
    vertex_queue.push_back(make_vertex(KIND_X, 9, ONE_Q16, -ONE_Q16, -16'sd12867));
    vertex_queue.push_back(make_vertex(KIND_X, 1, -ONE_Q16, ONE_Q16, 16'sd32767));
    vertex_queue.push_back(make_vertex(KIND_X, -1, ONE_Q16, ONE_Q16, -16'sd32768));
    vertex_queue.push_back(make_vertex(KIND_Z, COORD_MAX, COORD_MAX, 0, 16'sd3217));
    vertex_queue.push_back(make_vertex(KIND_Y, COORD_MIN, 0, COORD_MIN, 16'sd3217));
    vertex_queue.push_back(make_vertex(KIND_X, 0, COORD_MAX, COORD_MIN, -16'sd3217));
    vertex_queue.push_back(make_vertex(KIND_Z, COORD_MIN, COORD_MIN, COORD_MAX, 16'sd12868));
    vertex_queue.push_back(make_vertex(KIND_NONE, COORD_MAX, COORD_MIN, -1, 16'sd32767));
    vertex_queue.push_back(make_vertex(KIND_NONE, 0, 0, 0, -16'sd32768));
    vertex_queue.push_back(make_vertex(KIND_Z, COORD_MAX, COORD_MAX, COORD_MAX, 0));
    vertex_queue.push_back(make_vertex(KIND_X, -1, -1, -1, 16'sd1));
    vertex_queue.push_back(make_vertex(KIND_Y, 1, COORD_MIN, 1, -16'sd1));
    vertex_queue.push_back(make_vertex(KIND_Z, -1, 1, COORD_MIN, 16'sd32767));
    drain_all();

    for (n = 0; n < RANDOM_VERTICES; n++) begin
      k = $urandom_range(0, 9);
      vertex_queue.push_back(make_vertex((k == 9) ? KIND_NONE : 2'(k % 3), rand_coord(),
                                         rand_coord(), rand_coord(), rand_turn()));
      // let the pipe run dry once midway
      if (n == RANDOM_VERTICES / 2) drain_all();
    end
    drain_all();
    repeat (PIPE_DEPTH + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("axis_vector_rotation regression: pass");
    end else begin
      $display("axis_vector_rotation regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/avr_pkg.sv
sv/avr_if.sv
sv/avr_prep.sv
sv/avr_cell.sv
sv/avr_scale.sv
sv/axis_vector_rotation.sv
tb/axis_vector_rotation_tb.sv
